// File: hw/rtl/fsvic_pkg.sv
// Shared types and constants for the four-source vectored interrupt controller.
package fsvic_pkg;

    // Beat kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2,
        OP_ACK   = 2'd3
    } op_t;

    // Decoded register offsets
    localparam logic [3:0] ADDR_STATUS = 4'd1;
    localparam logic [3:0] ADDR_VBASE  = 4'd3;

    // Read value for undecoded offsets
    localparam logic [7:0] READ_UNDECODED = 8'hff;

    // Source bit positions, highest priority first
    localparam int SRC_FDC = 0;
    localparam int SRC_FDD = 1;
    localparam int SRC_HDC = 2;
    localparam int SRC_PRN = 3;

    // Field widths
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 8;
    localparam int SRC_W    = 2;
    localparam int NSRC     = 4;
    localparam int BASE_W   = 6;
    localparam int VEC_W    = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // One input beat, unpacked
    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   write_data;
        logic [SRC_W-1:0]    source;
        logic                level;
        logic                printer_ready;
    } fsvic_item_t;

    // One result beat
    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                irq_cancel;
        logic                irq_request;
        logic [VEC_W-1:0]    irq_vector;
        logic                irq_outstanding;
    } fsvic_result_t;

endpackage

// File: hw/rtl/fsvic_engine.sv
// Register file, priority evaluation and request tracking, one beat per cycle while take is high.
module fsvic_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  fsvic_pkg::fsvic_item_t item,
    output fsvic_pkg::fsvic_result_t result
);

    logic [fsvic_pkg::NSRC-1:0]   pending_reg, pending_next;
    logic [fsvic_pkg::NSRC-1:0]   enable_reg, enable_next;
    logic [fsvic_pkg::BASE_W-1:0] base_reg, base_next;
    logic [fsvic_pkg::VEC_W-1:0]  held_vector_reg, held_vector_next;
    logic                         held_valid_reg, held_valid_next;

    logic                         do_eval;
    logic [fsvic_pkg::NSRC-1:0]   active;
    logic [1:0]                   idx;
    logic [fsvic_pkg::VEC_W-1:0]  vec;
    logic [fsvic_pkg::DATA_W-1:0] rd;
    logic                         cancel;
    logic                         request;

    // Decode the beat and work out the new register contents
    always_comb begin
        pending_next = pending_reg;
        enable_next  = enable_reg;
        base_next    = base_reg;
        do_eval      = 1'b0;
        rd           = '0;
        unique case (item.op)
            fsvic_pkg::OP_READ: begin
                rd = fsvic_pkg::READ_UNDECODED;
                if (item.addr == fsvic_pkg::ADDR_STATUS) begin
                    rd = {pending_reg[fsvic_pkg::SRC_FDC], pending_reg[fsvic_pkg::SRC_FDD],
                          item.printer_ready, pending_reg[fsvic_pkg::SRC_HDC],
                          enable_reg[fsvic_pkg::SRC_HDC], enable_reg[fsvic_pkg::SRC_FDC],
                          enable_reg[fsvic_pkg::SRC_FDD], enable_reg[fsvic_pkg::SRC_PRN]};
                    // Status read acknowledges the printer
                    if (pending_reg[fsvic_pkg::SRC_PRN]) begin
                        pending_next[fsvic_pkg::SRC_PRN] = 1'b0;
                        do_eval = 1'b1;
                    end
                end
            end
            fsvic_pkg::OP_WRITE: begin
                if (item.addr == fsvic_pkg::ADDR_STATUS) begin
                    enable_next[fsvic_pkg::SRC_PRN] = item.write_data[0];
                    enable_next[fsvic_pkg::SRC_FDD] = item.write_data[1];
                    enable_next[fsvic_pkg::SRC_FDC] = item.write_data[2];
                    enable_next[fsvic_pkg::SRC_HDC] = item.write_data[3];
                    do_eval = 1'b1;
                end else if (item.addr == fsvic_pkg::ADDR_VBASE) begin
                    base_next = item.write_data[fsvic_pkg::DATA_W-1:2];
                end
            end
            fsvic_pkg::OP_LINE: begin
                pending_next[item.source] = item.level;
                do_eval = 1'b1;
            end
            fsvic_pkg::OP_ACK: begin
                do_eval = 1'b0;
            end
            default: begin
                do_eval = 1'b0;
            end
        endcase
    end

    // Pick the highest enabled pending source
    assign active = pending_next & enable_next;
    always_comb begin
        if (active[0])      idx = 2'd0;
        else if (active[1]) idx = 2'd1;
        else if (active[2]) idx = 2'd2;
        else                idx = 2'd3;
    end
    assign vec = {base_reg, idx};

    // Request, cancel or re-request the CPU interrupt
    always_comb begin
        held_vector_next = held_vector_reg;
        held_valid_next  = held_valid_reg;
        cancel           = 1'b0;
        request          = 1'b0;
        if (item.op == fsvic_pkg::OP_ACK) begin
            held_valid_next = 1'b0;
        end else if (do_eval) begin
            if (active == '0) begin
                cancel          = held_valid_reg;
                held_valid_next = 1'b0;
            end else if (!(held_valid_reg && held_vector_reg == vec)) begin
                cancel           = held_valid_reg;
                request          = 1'b1;
                held_vector_next = vec;
                held_valid_next  = 1'b1;
            end
        end
    end

    // Result of the current beat
    always_comb begin
        result.read_data       = rd;
        result.irq_cancel      = cancel;
        result.irq_request     = request;
        result.irq_vector      = held_valid_next ? held_vector_next : '0;
        result.irq_outstanding = held_valid_next;
    end

    // Commit state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg     <= '0;
            enable_reg      <= '0;
            base_reg        <= '0;
            held_vector_reg <= '0;
            held_valid_reg  <= 1'b0;
        end else if (take) begin
            pending_reg     <= pending_next;
            enable_reg      <= enable_next;
            base_reg        <= base_next;
            held_vector_reg <= held_vector_next;
            held_valid_reg  <= held_valid_next;
        end
    end

endmodule

// File: hw/rtl/four_source_vectored_irq_controller_core.sv
// Top level of the four-source vectored interrupt controller.
//
// Input stream (s_*): one beat per bus read, bus write, source line change
// or interrupt acknowledge; s_tuser gives the kind, s_tdata the operands.
// Output stream (m_*): exactly one result beat per input beat, in order,
// carrying read data, cancel/request strobes and the outstanding vector.
//
// The result of an accepted beat is registered in the output register, or in
// the skid register while the output register is held, and offered on m_*
// from there. Throughput is one beat per cycle while s_tready is high.
// A two-entry output (result register plus skid register) keeps s_tready
// high while one result waits; s_tready drops only when both are full, so
// a stalled receiver holds the block after two results.
//
// Reset (aresetn low, synchronous) clears pending and enable bits, the
// vector base and the remembered request, and empties the output stage.
module four_source_vectored_irq_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // addr[3:0], write_data[11:4], source[13:12], level[14], printer_ready[15]
    input  logic [fsvic_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_data[7:0], irq_cancel[8], irq_request[9], irq_vector[17:10],
    // irq_outstanding[18], zero[23:19]
    output logic [fsvic_pkg::M_TDATA_W-1:0]   m_tdata
);

    fsvic_pkg::fsvic_item_t   item;
    fsvic_pkg::fsvic_result_t result;
    fsvic_pkg::fsvic_result_t out_reg;
    fsvic_pkg::fsvic_result_t skid_reg;
    logic                     out_valid_reg;
    logic                     skid_valid_reg;
    logic                     take;
    logic                     out_free;

    // Unpack the input beat
    always_comb begin
        item.op            = fsvic_pkg::op_t'(s_tuser);
        item.addr          = s_tdata[3:0];
        item.write_data    = s_tdata[11:4];
        item.source        = s_tdata[13:12];
        item.level         = s_tdata[14];
        item.printer_ready = s_tdata[15];
    end

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    fsvic_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .result  (result)
    );

    // Output register and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (!out_free && take) begin
            skid_reg <= result;
        end
    end

    // Pack the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.irq_outstanding, out_reg.irq_vector,
                       out_reg.irq_request, out_reg.irq_cancel, out_reg.read_data};

    // Skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // A fresh request always leaves a request outstanding
    a_request_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.irq_request) |-> out_reg.irq_outstanding)
        else $error("request without outstanding flag");

    // A bare cancel leaves nothing outstanding
    a_cancel_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.irq_cancel && !out_reg.irq_request)
            |-> !out_reg.irq_outstanding)
        else $error("cancel left a request outstanding");

    // Vector reads zero when nothing is outstanding
    a_vector_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.irq_outstanding) |-> (out_reg.irq_vector == '0))
        else $error("vector shown with nothing outstanding");

endmodule

// File: verif/fsvic_checker.sv
// Scoreboard for the interrupt controller: mirrors its state, predicts each result beat and compares.
`timescale 1ns / 1ps

module fsvic_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // addr[3:0], write_data[11:4], source[13:12], level[14], printer_ready[15]
    input  logic [fsvic_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data[7:0], irq_cancel[8], irq_request[9], irq_vector[17:10],
    // irq_outstanding[18], zero[23:19]
    input  logic [fsvic_pkg::M_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              expected_left,
    output int                              results_checked,
    output int                              requests_seen
);

    // Shadow copy of the controller state
    logic [fsvic_pkg::NSRC-1:0]   pend_q;
    logic [fsvic_pkg::NSRC-1:0]   en_q;
    logic [fsvic_pkg::BASE_W-1:0] base_hi_q;
    logic [fsvic_pkg::VEC_W-1:0]  held_vec_q;
    logic                         held_ok_q;
    logic                         cancel_now;
    logic                         request_now;

    int n_fail;
    int n_checked;
    int n_requests;

    fsvic_pkg::fsvic_result_t irq_results_due[$];

    // Pick the highest enabled pending source and update the held request
    function automatic void rearbitrate();
        logic [fsvic_pkg::NSRC-1:0]  active;
        logic [fsvic_pkg::VEC_W-1:0] vec;
        int                          idx;
        active = pend_q & en_q;
        if (active == '0) begin
            if (held_ok_q) begin
                cancel_now = 1'b1;
                held_ok_q  = 1'b0;
            end
            return;
        end
        idx = 0;
        while (!active[idx])
            idx++;
        vec = {base_hi_q, 2'b00} + fsvic_pkg::VEC_W'(idx);
        if (held_ok_q && held_vec_q == vec)
            return;
        if (held_ok_q)
            cancel_now = 1'b1;
        request_now = 1'b1;
        held_vec_q  = vec;
        held_ok_q   = 1'b1;
    endfunction

    // Apply one input beat to the shadow state and form its result
    function automatic fsvic_pkg::fsvic_result_t irq_ctrl_step(
            input fsvic_pkg::fsvic_item_t beat);
        fsvic_pkg::fsvic_result_t res;
        res         = '0;
        cancel_now  = 1'b0;
        request_now = 1'b0;
        case (beat.op)
            fsvic_pkg::OP_READ: begin
                res.read_data = fsvic_pkg::READ_UNDECODED;
                if (beat.addr == fsvic_pkg::ADDR_STATUS) begin
                    res.read_data = {pend_q[fsvic_pkg::SRC_FDC], pend_q[fsvic_pkg::SRC_FDD],
                                     beat.printer_ready, pend_q[fsvic_pkg::SRC_HDC],
                                     en_q[fsvic_pkg::SRC_HDC], en_q[fsvic_pkg::SRC_FDC],
                                     en_q[fsvic_pkg::SRC_FDD], en_q[fsvic_pkg::SRC_PRN]};
                    // a status read acknowledges the printer
                    if (pend_q[fsvic_pkg::SRC_PRN]) begin
                        pend_q[fsvic_pkg::SRC_PRN] = 1'b0;
                        rearbitrate();
                    end
                end
            end
            fsvic_pkg::OP_WRITE: begin
                if (beat.addr == fsvic_pkg::ADDR_STATUS) begin
                    en_q[fsvic_pkg::SRC_PRN] = beat.write_data[0];
                    en_q[fsvic_pkg::SRC_FDD] = beat.write_data[1];
                    en_q[fsvic_pkg::SRC_FDC] = beat.write_data[2];
                    en_q[fsvic_pkg::SRC_HDC] = beat.write_data[3];
                    rearbitrate();
                end else if (beat.addr == fsvic_pkg::ADDR_VBASE) begin
                    // new base only takes effect at the next arbitration
                    base_hi_q = beat.write_data[7:2];
                end
            end
            fsvic_pkg::OP_LINE: begin
                pend_q[beat.source] = beat.level;
                rearbitrate();
            end
            default: begin
                held_ok_q = 1'b0;
            end
        endcase
        res.irq_cancel      = cancel_now;
        res.irq_request     = request_now;
        res.irq_vector      = held_ok_q ? held_vec_q : '0;
        res.irq_outstanding = held_ok_q;
        return res;
    endfunction

    function automatic int field_bad(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        return 1;
    endfunction

    // Predict on input beats, compare on result beats
    always @(posedge aclk) begin
        fsvic_pkg::fsvic_item_t   beat;
        fsvic_pkg::fsvic_result_t want;
        if (!aresetn) begin
            pend_q     = '0;
            en_q       = '0;
            base_hi_q  = '0;
            held_vec_q = '0;
            held_ok_q  = 1'b0;
            irq_results_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                beat.op            = fsvic_pkg::op_t'(s_tuser);
                beat.addr          = s_tdata[3:0];
                beat.write_data    = s_tdata[11:4];
                beat.source        = s_tdata[13:12];
                beat.level         = s_tdata[14];
                beat.printer_ready = s_tdata[15];
                irq_results_due.push_back(irq_ctrl_step(beat));
            end
            if (m_tvalid && m_tready) begin
                if (irq_results_due.size() == 0) begin
                    $error("result beat with nothing predicted: m_tdata=0x%06h", m_tdata);
                    n_fail++;
                end else begin
                    want = irq_results_due.pop_front();
                    n_checked++;
                    if (m_tdata[9])
                        n_requests++;
                    n_fail += field_bad("read_data", want.read_data, m_tdata[7:0]);
                    n_fail += field_bad("irq_cancel", want.irq_cancel, m_tdata[8]);
                    n_fail += field_bad("irq_request", want.irq_request, m_tdata[9]);
                    n_fail += field_bad("irq_vector", want.irq_vector, m_tdata[17:10]);
                    n_fail += field_bad("irq_outstanding", want.irq_outstanding,
                                        m_tdata[18]);
                end
            end
        end
        fail_count      <= n_fail;
        expected_left   <= irq_results_due.size();
        results_checked <= n_checked;
        requests_seen   <= n_requests;
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the interrupt controller: clock, reset, beat stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_BEATS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    // addr[3:0], write_data[11:4], source[13:12], level[14], printer_ready[15]
    logic [fsvic_pkg::S_TDATA_W-1:0] s_tdata;
    // op[1:0]
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // read_data[7:0], irq_cancel[8], irq_request[9], irq_vector[17:10],
    // irq_outstanding[18], zero[23:19]
    logic [fsvic_pkg::M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int expected_left;
    int results_checked;
    int requests_seen;

    int burst_left;
    int idle_cycles;
    int op_count [4];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    four_source_vectored_irq_controller_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fsvic_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked),
        .requests_seen   (requests_seen)
    );

    function automatic fsvic_pkg::fsvic_item_t mk_beat(input fsvic_pkg::op_t op,
                                                       input logic [3:0] addr,
                                                       input logic [7:0] wd, input int src,
                                                       input logic lvl, input logic rdy);
        fsvic_pkg::fsvic_item_t b;
        b.op            = op;
        b.addr          = addr;
        b.write_data    = wd;
        b.source        = fsvic_pkg::SRC_W'(src);
        b.level         = lvl;
        b.printer_ready = rdy;
        return b;
    endfunction

    // Random beat, weighted towards decoded registers and line activity
    function automatic fsvic_pkg::fsvic_item_t rand_beat();
        fsvic_pkg::fsvic_item_t b;
        int                     pick;
        int                     sel;
        b.op            = fsvic_pkg::OP_LINE;
        b.addr          = 4'($urandom_range(0, 15));
        b.write_data    = 8'($urandom_range(0, 255));
        b.source        = fsvic_pkg::SRC_W'($urandom_range(0, 3));
        b.level         = 1'($urandom_range(0, 1));
        b.printer_ready = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            b.op = fsvic_pkg::OP_READ;
            if ($urandom_range(0, 1) == 1)
                b.addr = fsvic_pkg::ADDR_STATUS;
        end else if (pick < 50) begin
            b.op = fsvic_pkg::OP_WRITE;
            sel  = $urandom_range(0, 9);
            if (sel < 4)
                b.addr = fsvic_pkg::ADDR_STATUS;
            else if (sel < 7)
                b.addr = fsvic_pkg::ADDR_VBASE;
        end else if (pick >= 85) begin
            b.op = fsvic_pkg::OP_ACK;
        end
        return b;
    endfunction

    // Offer one beat, hold it until accepted, then maybe leave a gap
    task automatic push_beat(input fsvic_pkg::fsvic_item_t beat);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= beat.op;
        s_tdata  <= {beat.printer_ready, beat.level, beat.source, beat.write_data, beat.addr};
        do @(posedge aclk); while (!s_tready);
        op_count[beat.op]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
    endtask

    // Receiver: switch at random between stall patterns
    initial begin
        int mode;
        int hold;
        int phase;
        m_tready <= 1'b0;
        phase = 0;
        forever begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(20, 120);
            repeat (hold) begin
                @(posedge aclk);
                phase = (phase + 1) % 9;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase < 3);
                endcase
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("four_source_vectored_irq_controller_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fsvic_pkg::fsvic_item_t directed [$];
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= fsvic_pkg::OP_READ;
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: undecoded offsets, base and enable extremes, priority changes,
        // printer clear on status read, stale vector after base write, acknowledges
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  fsvic_pkg::ADDR_STATUS, 8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b1));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  fsvic_pkg::ADDR_VBASE,  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, fsvic_pkg::ADDR_VBASE,  8'hff,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, fsvic_pkg::ADDR_STATUS, 8'hff,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_FDD, 1'b1, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_PRN, 1'b1, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b1, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, fsvic_pkg::ADDR_VBASE,  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  fsvic_pkg::ADDR_STATUS, 8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_ACK,   4'h0,                  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_ACK,   4'hf,                  8'hff,
                                   fsvic_pkg::SRC_PRN, 1'b1, 1'b1));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_HDC, 1'b1, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_FDD, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, fsvic_pkg::ADDR_STATUS, 8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, fsvic_pkg::ADDR_STATUS, 8'hf8,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  fsvic_pkg::ADDR_STATUS, 8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b1));
        directed.push_back(mk_beat(fsvic_pkg::OP_LINE,  4'h0,                  8'h00,
                                   fsvic_pkg::SRC_PRN, 1'b1, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, fsvic_pkg::ADDR_STATUS, 8'h01,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  fsvic_pkg::ADDR_STATUS, 8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b1));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, 4'hf,                  8'haa,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  4'hf,                  8'h00,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_WRITE, 4'h2,                  8'h55,
                                   fsvic_pkg::SRC_FDC, 1'b0, 1'b0));
        directed.push_back(mk_beat(fsvic_pkg::OP_READ,  4'hd,                  8'h00,
                                   fsvic_pkg::SRC_HDC, 1'b0, 1'b0));
        foreach (directed[i])
            push_beat(directed[i]);
        drain_results();

        // Random traffic, with a full drain now and then
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 280 == 140)
                drain_results();
            push_beat(rand_beat());
        end

        // Let the last results out, then wait quietly before the verdict
        drain_results();
        repeat (4) @(posedge aclk);

        $display("Sent %0d beats: %0d reads, %0d writes, %0d line changes, %0d acknowledges",
                 op_count[fsvic_pkg::OP_READ] + op_count[fsvic_pkg::OP_WRITE] +
                 op_count[fsvic_pkg::OP_LINE] + op_count[fsvic_pkg::OP_ACK],
                 op_count[fsvic_pkg::OP_READ], op_count[fsvic_pkg::OP_WRITE],
                 op_count[fsvic_pkg::OP_LINE], op_count[fsvic_pkg::OP_ACK]);
        $display("Compared %0d result beats, %0d carrying a fresh interrupt request",
                 results_checked, requests_seen);
        if (fail_count == 0 && expected_left == 0) begin
            $display("four_source_vectored_irq_controller_core verification clean");
        end else begin
            $display("four_source_vectored_irq_controller_core verification failed");
        end
        $finish;
    end

endmodule
